// File: sv/rort_pkg.sv
// ----------------------------------------------------------------------------
// rort_pkg
// Shared types and constants for the range offset remap table.
// ----------------------------------------------------------------------------
`default_nettype none

package rort_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_VALUE = 2'd1,
        CMD_RANGE = 2'd2
    } cmd_t;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_ZERO_LEN = 2'd2;

    typedef struct packed {
        logic hit;
        logic found;
    } scan_flags_t;

endpackage

`default_nettype wire

// File: sv/rort_mem.sv
// ----------------------------------------------------------------------------
// rort_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rort_mem #(
    parameter int DEPTH = 16,
    parameter int DW    = 96,
    parameter int AW    = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata,
    output logic               rvalid
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;
    logic          rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= re;
        end
    end

    assign rdata  = rdata_reg;
    assign rvalid = rvalid_reg;

endmodule

`default_nettype wire

// File: sv/rort_scan.sv
// ----------------------------------------------------------------------------
// rort_scan
// Per-entry scan: first containing entry, and smallest entry endpoint
// strictly between the current point and the range end.
// ----------------------------------------------------------------------------
`default_nettype none

module rort_scan #(
    parameter int W = 32
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            clear,
    input  wire logic            in_valid,
    input  wire logic [W-1:0]    src,
    input  wire logic [W-1:0]    dst,
    input  wire logic [W-1:0]    len,
    input  wire logic [W:0]      cur,
    input  wire logic [W:0]      qe,
    output rort_pkg::scan_flags_t flags,
    output logic      [W-1:0]    mapped,
    output logic      [W:0]      next_pt
);
    import rort_pkg::*;

    scan_flags_t flags_reg;
    logic [W-1:0] mapped_reg;
    logic [W:0]   next_reg;
    logic [W:0]   src_x;
    logic [W:0]   end_x;
    logic [W:0]   diff;
    logic         contains;
    logic         c1;
    logic         c2;
    logic [W:0]   cand;
    logic         take;

    always_comb
    begin
        src_x    = {1'b0, src};
        end_x    = {1'b0, src} + {1'b0, len};
        diff     = cur - src_x;
        contains = (src_x <= cur) && (diff < {1'b0, len});
        c1       = (src_x > cur) && (src_x < qe);
        c2       = (end_x > cur) && (end_x < qe);
        cand     = c1 ? src_x : end_x;
        take     = (c1 || c2) && (!flags_reg.found || (cand < next_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (clear)
        begin
            flags_reg <= '0;
        end
        else if (in_valid)
        begin
            if (contains)
            begin
                flags_reg.hit <= 1'b1;
            end
            if (take)
            begin
                flags_reg.found <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!clear && in_valid)
        begin
            if (contains && !flags_reg.hit)
            begin
                mapped_reg <= cur[W-1:0] + dst - src;
            end
            if (take)
            begin
                next_reg <= cand;
            end
        end
    end

    assign flags   = flags_reg;
    assign mapped  = mapped_reg;
    assign next_pt = next_reg;

endmodule

`default_nettype wire

// File: sv/range_offset_remap_table.sv
// ----------------------------------------------------------------------------
// range_offset_remap_table
// Remap table with add, value lookup and range split-and-map commands.
// ----------------------------------------------------------------------------
// One item at a time. An add writes the entry on acceptance, then hands its
// status to the output register. A value lookup makes one memory read per
// stored entry through the single read port (none with an empty table), then
// gives the result. A range lookup emits P pieces (1 to 2N+1), N being the
// number of stored entries, and runs a full scan for each piece, since every
// piece rescans the whole table for its containing entry and the next endpoint.
// An input item is taken while the previous result waits in the output
// register. No clearing pass after reset.
`default_nettype none

module range_offset_remap_table #(
    parameter int MAX_ENTRIES = rort_pkg::MAX_ENTRIES_DEF,
    parameter int VALUE_WIDTH = rort_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // query_start, query_length, entry_source, entry_dest, entry_length
    input  wire logic [((5*VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // command
    input  wire logic [1:0] s_axis_tuser,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // mapped_start, piece_length
    output logic [((2*VALUE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // matched, status
    output logic [2:0] m_axis_tuser,
    output logic       m_axis_tlast
);
    import rort_pkg::*;

    localparam int W     = VALUE_WIDTH;
    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int ODW   = ((2*VALUE_WIDTH+7)/8)*8;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_ADD  = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic [W:0]  cur_reg, cur_next;
    logic [W:0]  qe_reg, qe_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]  add_status_reg, add_status_next;

    logic         m_valid_reg, m_valid_next;
    logic [W-1:0] m_mapped_reg, m_mapped_next;
    logic [W-1:0] m_len_reg, m_len_next;
    logic         m_match_reg, m_match_next;
    logic         m_last_reg, m_last_next;
    logic [1:0]   m_status_reg, m_status_next;

    logic [W-1:0] qs, ql, es, ed, el;
    logic         accept, out_free, scan_done, rd_en, we, scan_clear;
    logic [1:0]   add_status;
    logic [3*W-1:0] rdata;
    logic         rvalid;
    scan_flags_t  flags;
    logic [W-1:0] scan_mapped;
    logic [W:0]   next_pt;
    logic [W:0]   nxt;

    assign qs = s_axis_tdata[W-1:0];
    assign ql = s_axis_tdata[2*W-1:W];
    assign es = s_axis_tdata[3*W-1:2*W];
    assign ed = s_axis_tdata[4*W-1:3*W];
    assign el = s_axis_tdata[5*W-1:4*W];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign rd_en         = (state_reg == ST_SCAN) && (issue_reg != count_reg);
    assign scan_done     = (state_reg == ST_SCAN) && (issue_reg == count_reg) && !rvalid;

    always_comb
    begin
        if (count_reg == CW'(MAX_ENTRIES))
        begin
            add_status = STAT_FULL;
        end
        else if (el == '0)
        begin
            add_status = STAT_ZERO_LEN;
        end
        else
        begin
            add_status = STAT_OK;
        end
    end

    assign we  = accept && (s_axis_tuser == CMD_ADD) && (add_status == STAT_OK);
    assign nxt = flags.found ? next_pt : qe_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        cur_next        = cur_reg;
        qe_next         = qe_reg;
        issue_next      = issue_reg;
        count_next      = count_reg;
        add_status_next = add_status_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_mapped_next   = m_mapped_reg;
        m_len_next      = m_len_reg;
        m_match_next    = m_match_reg;
        m_last_next     = m_last_reg;
        m_status_next   = m_status_reg;
        scan_clear      = 1'b0;

        if (rd_en)
        begin
            issue_next = issue_reg + 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = s_axis_tuser;
                    cur_next   = {1'b0, qs};
                    qe_next    = {1'b0, qs} + {1'b0, ql};
                    issue_next = '0;
                    case (s_axis_tuser)
                        CMD_ADD:
                        begin
                            add_status_next = add_status;
                            if (add_status == STAT_OK)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            state_next = ST_ADD;
                        end
                        CMD_VALUE, CMD_RANGE:
                        begin
                            scan_clear = 1'b1;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ADD:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_mapped_next = '0;
                    m_len_next    = '0;
                    m_match_next  = 1'b0;
                    m_last_next   = 1'b1;
                    m_status_next = add_status_reg;
                    state_next    = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (scan_done && out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_mapped_next = flags.hit ? scan_mapped : cur_reg[W-1:0];
                    m_match_next  = flags.hit;
                    m_status_next = STAT_OK;
                    if (cmd_reg == CMD_RANGE)
                    begin
                        m_len_next  = W'(nxt - cur_reg);
                        m_last_next = !flags.found;
                        cur_next    = nxt;
                        if (flags.found)
                        begin
                            issue_next = '0;
                            scan_clear = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        m_len_next  = '0;
                        m_last_next = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            issue_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            issue_reg   <= issue_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        cur_reg        <= cur_next;
        qe_reg         <= qe_next;
        add_status_reg <= add_status_next;
        m_mapped_reg   <= m_mapped_next;
        m_len_reg      <= m_len_next;
        m_match_reg    <= m_match_next;
        m_last_reg     <= m_last_next;
        m_status_reg   <= m_status_next;
    end

    rort_mem #(
        .DEPTH (MAX_ENTRIES),
        .DW    (3*W),
        .AW    (AW)
    ) u_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (we),
        .waddr  (count_reg[AW-1:0]),
        .wdata  ({el, ed, es}),
        .re     (rd_en),
        .raddr  (issue_reg[AW-1:0]),
        .rdata  (rdata),
        .rvalid (rvalid)
    );

    rort_scan #(
        .W (W)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (scan_clear),
        .in_valid (rvalid),
        .src      (rdata[W-1:0]),
        .dst      (rdata[2*W-1:W]),
        .len      (rdata[3*W-1:2*W]),
        .cur      (cur_reg),
        .qe       (qe_reg),
        .flags    (flags),
        .mapped   (scan_mapped),
        .next_pt  (next_pt)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = ODW'({m_len_reg, m_mapped_reg});
    assign m_axis_tuser  = {m_status_reg, m_match_reg};
    assign m_axis_tlast  = m_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    a_read_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (issue_reg < count_reg))
        else $error("read beyond stored entries");

    a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (state_reg == ST_IDLE) && (count_reg < CW'(MAX_ENTRIES)))
        else $error("table write outside idle or into full table");

endmodule

`default_nettype wire

// File: bench/range_offset_remap_table_tb.sv
// ----------------------------------------------------------------------------
// range_offset_remap_table_tb
// Drives add, value, range and unused commands with random gaps and output
// stalls, predicts every result from a local table copy, checks each field.
// ----------------------------------------------------------------------------
`default_nettype none

module range_offset_remap_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rort_pkg::*;

    localparam int NENT = 16;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [31:0] mstart;
        logic [31:0] plen;
        logic        hit;
        logic        last;
        logic [1:0]  stat;
    } remap_res_t;

    class remap_scoreboard;
        logic [31:0] src_tab[NENT];
        logic [31:0] dst_tab[NENT];
        logic [31:0] len_tab[NENT];
        int          n_ent;
        remap_res_t  pending[$];
        int          errors;

        function void add_expected(input remap_res_t r);
            pending = {pending, r};
        endfunction

        function void map_value(input logic [32:0] v, output logic [31:0] m,
                                output logic h);
            logic [32:0] s;
            m = v[31:0];
            h = 1'b0;
            for (int i = 0; i < n_ent; i++) begin
                s = {1'b0, src_tab[i]};
                if (!h && s <= v && (v - s) < {1'b0, len_tab[i]}) begin
                    h = 1'b1;
                    m = v[31:0] + dst_tab[i] - src_tab[i];
                end
            end
        endfunction

        function void note_item(input logic [1:0] cmd, input logic [31:0] qs,
                                input logic [31:0] ql, input logic [31:0] es,
                                input logic [31:0] ed, input logic [31:0] el);
            remap_res_t r;
            logic [32:0] cuts[$];
            logic [32:0] qe, cur, nxt, p;
            logic [31:0] m;
            logic h;
            r = '0;
            r.last = 1'b1;
            if (cmd == CMD_ADD) begin
                if (n_ent >= NENT) r.stat = STAT_FULL;
                else if (el == 0) r.stat = STAT_ZERO_LEN;
                else begin
                    src_tab[n_ent] = es;
                    dst_tab[n_ent] = ed;
                    len_tab[n_ent] = el;
                    n_ent++;
                end
                add_expected(r);
            end else if (cmd == CMD_VALUE) begin
                map_value({1'b0, qs}, m, h);
                r.mstart = m;
                r.hit = h;
                add_expected(r);
            end else if (cmd == CMD_RANGE) begin
                qe = {1'b0, qs} + {1'b0, ql};
                for (int i = 0; i < n_ent; i++) begin
                    for (int e = 0; e < 2; e++) begin
                        p = e ? {1'b0, src_tab[i]} + {1'b0, len_tab[i]}
                              : {1'b0, src_tab[i]};
                        if (p > {1'b0, qs} && p < qe) cuts = {cuts, p};
                    end
                end
                cuts = cuts.unique();
                cuts.sort();
                cur = {1'b0, qs};
                for (int k = 0; k <= cuts.size(); k++) begin
                    nxt = (k < cuts.size()) ? cuts[k] : qe;
                    map_value(cur, m, h);
                    r = '0;
                    r.mstart = m;
                    r.plen = nxt[31:0] - cur[31:0];
                    r.hit = h;
                    r.last = (k == cuts.size());
                    add_expected(r);
                    cur = nxt;
                end
            end
        endfunction

        function void check_result(input remap_res_t got);
            remap_res_t exp;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp start %h len %h hit %b last %b st %0d, ",
                              "got start %h len %h hit %b last %b st %0d"},
                             exp.mstart, exp.plen, exp.hit, exp.last, exp.stat,
                             got.mstart, got.plen, got.hit, got.last, got.stat);
            end
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // query_start, query_length, entry_source, entry_dest, entry_length
    logic [159:0] s_axis_tdata = '0;
    // command
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // mapped_start, piece_length
    logic [63:0]  m_axis_tdata;
    // matched, status
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;

    remap_scoreboard sb = new();
    bit   hold_out = 0;
    int   idle_cycles = 0;

    range_offset_remap_table uut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // called at a falling edge; leaves tvalid high for the next item
    task automatic send_item(input logic [1:0] cmd, input logic [31:0] qs,
                             input logic [31:0] ql, input logic [31:0] es,
                             input logic [31:0] ed, input logic [31:0] el);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {el, ed, es, ql, qs};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_item(cmd, qs, ql, es, ed, el);
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (40 * 35) @(negedge clk);
    endtask

    function automatic logic [31:0] near_table();
        int i;
        if (sb.n_ent == 0 || $urandom_range(0, 4) == 0) return $urandom();
        i = $urandom_range(0, sb.n_ent - 1);
        return sb.src_tab[i] + sb.len_tab[i] + 32'($urandom_range(0, 2)) - 32'd1;
    endfunction

    task automatic random_item();
        int sel;
        logic [31:0] a, b;
        sel = $urandom_range(0, 19);
        a = $urandom();
        if (sel < 4) begin
            b = ($urandom_range(0, 1)) ? 32'($urandom_range(1, 4000)) : $urandom();
            send_item(CMD_ADD, $urandom(), $urandom(),
                      $urandom_range(0, 1) ? 32'($urandom_range(0, 20000)) : a,
                      $urandom(), (sel == 0) ? 32'd0 : b);
        end else if (sel < 9) begin
            send_item(CMD_VALUE, near_table(), $urandom(), $urandom(), $urandom(),
                      $urandom());
        end else if (sel < 19) begin
            send_item(CMD_RANGE, near_table(),
                      $urandom_range(0, 1) ? 32'($urandom_range(0, 30000)) : $urandom(),
                      $urandom(), $urandom(), $urandom());
        end else begin
            send_item(CMD_UNUSED, $urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom());
        end
    endtask

    // result side: a random wait before each item, plus a long hold-off on request
    initial
    begin
        int wait_n;
        forever
        begin
            @(negedge clk);
            wait_n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
            if (hold_out) begin
                wait_n = 300;
                hold_out = 0;
            end
            if (wait_n != 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_n) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin
        remap_res_t r;
        if (m_axis_tvalid && m_axis_tready) begin
            r.mstart = m_axis_tdata[31:0];
            r.plen = m_axis_tdata[63:32];
            r.hit = m_axis_tuser[0];
            r.stat = m_axis_tuser[2:1];
            r.last = m_axis_tlast;
            sb.check_result(r);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("range_offset_remap_table test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // empty table
        send_item(CMD_VALUE, 32'hFFFF_FFFF, 0, 0, 0, 0);
        send_item(CMD_RANGE, 32'd5, 32'd0, 0, 0, 0);
        send_item(CMD_RANGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
        send_item(CMD_ADD, 0, 0, 32'd100, 32'd500, 32'd0);
        send_item(CMD_ADD, 0, 0, 32'd100, 32'd500, 32'd50);
        send_item(CMD_ADD, 0, 0, 32'hFFFF_FFF0, 32'd0, 32'hFFFF_FFFF);
        send_item(CMD_ADD, 0, 0, 32'd0, 32'hFFFF_FFFF, 32'd10);
        send_item(CMD_VALUE, 32'd100, 0, 0, 0, 0);
        send_item(CMD_VALUE, 32'd149, 0, 0, 0, 0);
        send_item(CMD_VALUE, 32'd150, 0, 0, 0, 0);
        send_item(CMD_VALUE, 32'hFFFF_FFFF, 0, 0, 0, 0);
        send_item(CMD_VALUE, 32'd0, 0, 0, 0, 0);
        send_item(CMD_RANGE, 32'd0, 32'd200, 0, 0, 0);
        send_item(CMD_RANGE, 32'd120, 32'd0, 0, 0, 0);
        send_item(CMD_RANGE, 32'hFFFF_FFF8, 32'hFFFF_FFFF, 0, 0, 0);
        send_item(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // pause until every result is in
        drain();
        // fill the table, then hit the full case
        for (int i = 0; i < 14; i++)
            send_item(CMD_ADD, 0, 0, 32'(i * 37 + 3), $urandom(),
                      32'($urandom_range(1, 60)));
        send_item(CMD_ADD, 0, 0, 32'd1, 32'd1, 32'd0);
        send_item(CMD_ADD, 0, 0, 32'd1, 32'd1, 32'd1);
        send_item(CMD_RANGE, 32'd0, 32'hFFFF_FFFF, 0, 0, 0);
        // long output hold-off while inputs keep coming
        hold_out = 1;
        for (int i = 0; i < 8; i++)
            send_item(CMD_VALUE, $urandom_range(0, 700), 0, 0, 0, 0);
        drain();
        // random phase against the full table
        for (int i = 0; i < 130; i++) random_item();
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("range_offset_remap_table test passed");
        else
            $display("range_offset_remap_table test failed");
        $finish;
    end
endmodule
